### rtl/pcs_pkg.sv
// Package for the PUCT child selector: widths, sequencer states, status codes
// and the step structs of the shared compare-subtract unit. No dependencies.
`timescale 1ns / 1ps
package pcs_pkg;

  localparam int IdBits    = 16;
  localparam int VisitBits = 20;
  localparam int SumBits   = 32;
  localparam int PriorBits = 16;
  localparam int WgtBits   = 16;
  localparam int RootBits  = 18;
  localparam int AccBits   = 36;
  localparam int RemBits   = 22;
  localparam int QBits     = 33;
  localparam int UBits     = 30;
  localparam int ScoreBits = 34;
  localparam int CntBits   = 6;
  localparam int DivSteps  = 32;
  localparam int SqrtSteps = 18;
  localparam logic [WgtBits-1:0] WgtReset = 16'd4096;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_EMPTY      = 2'd1,
    ST_PARENTZERO = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SQRT, S_QDIV, S_MUL1, S_MUL2, S_UDIV, S_CMP, S_FINISH
  } state_t;

  typedef enum logic {
    OP_DIV,
    OP_SQRT
  } op_t;

  // Operands of one step of the shared unit
  typedef struct packed {
    op_t                 op;
    logic [RemBits-1:0]  rem;
    logic [1:0]          top;
    logic [VisitBits:0]  divisor;
    logic [RootBits-1:0] root;
  } step_req_t;

  // Outcome of one step
  typedef struct packed {
    logic [RemBits-1:0] rem;
    logic               qbit;
  } step_rsp_t;

endpackage

### rtl/pcs_in_if.sv
// Input channel of the PUCT child selector: valid/ready plus one child item.
// Depends on pcs_pkg.
`timescale 1ns / 1ps
interface pcs_in_if
  import pcs_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [IdBits-1:0]     child_id;
  logic [VisitBits-1:0]  child_visits;
  logic signed [SumBits-1:0] child_value_sum;
  logic [PriorBits-1:0]  child_prior;
  logic [VisitBits-1:0]  parent_visits;
  logic                  empty_group;
  logic                  last_child;

  modport source (output valid, child_id, child_visits, child_value_sum, child_prior,
                  parent_visits, empty_group, last_child, input ready);
  modport sink (input valid, child_id, child_visits, child_value_sum, child_prior,
                parent_visits, empty_group, last_child, output ready);
endinterface

### rtl/pcs_out_if.sv
// Result channel of the PUCT child selector: valid/ready plus best child and status.
// Depends on pcs_pkg.
`timescale 1ns / 1ps
interface pcs_out_if
  import pcs_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [IdBits-1:0] best_child;
  logic [1:0]        status;

  modport source (output valid, best_child, status, input ready);
  modport sink (input valid, best_child, status, output ready);
endinterface

### rtl/puct_child_selector.sv
// PUCT child selector top level: sequencer, operand registers, multiplier
// and best-score tracking. Depends on pcs_pkg, pcs_in_if, pcs_out_if, pcs_step_unit.
`timescale 1ns / 1ps
//
// Usage:
//   in_ch carries one child of a tree node per item; last_child closes the
//   group, empty_group reports a node without children. out_ch carries one
//   result per group: best child id and status (ok, no children, parent
//   count zero). cfg_we/cfg_wdata write the Q4.12 exploration weight while idle.
// Timing:
//   The block takes one item at a time; in_ch.ready is high only while the
//   sequencer is idle. Each child goes through one shared compare-subtract
//   unit: 18 square root steps on a group's first child, 32 steps for Q
//   (skipped when the child is unvisited), states S_MUL1 and S_MUL2 to multiply,
//   32 steps for U and a compare state. S_FINISH follows a group's last child
//   or an empty-group item and loads the result once out_ch is free. The user
//   must write the weight only while idle; the block does not enforce this.
// Reset:
//   rst (synchronous, active high) closes any open group, clears the result
//   valid flag and sets the weight to 1.0.
// Stall:
//   A result waits in the output register; the next item is taken meanwhile,
//   and only a second result stalls the sequencer until out_ch.ready.
//
module puct_child_selector
  import pcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [WgtBits-1:0] cfg_wdata,
  pcs_in_if.sink             in_ch,
  pcs_out_if.source          out_ch
);

  state_t state, state_next;

  logic [WgtBits-1:0]   weight;
  logic [CntBits-1:0]   cnt;
  logic [AccBits-1:0]   acc;
  logic [RemBits-1:0]   rem;
  logic [RootBits-1:0]  root;
  logic [RootBits-1:0]  parent_root;
  logic                 parent_zero;
  logic                 in_group;
  logic                 first;
  logic                 last;
  logic                 empty;
  logic                 neg;
  logic [IdBits-1:0]    id;
  logic [VisitBits-1:0] visits;
  logic [PriorBits-1:0] prior;
  logic signed [QBits-1:0]     q;
  logic [UBits-1:0]     u;
  logic [31:0]          prod1;
  logic signed [ScoreBits-1:0] best_score;
  logic [IdBits-1:0]    best_id;
  logic [SumBits-1:0]   sum_mag;

  logic [SumBits-1:0]   mag;
  logic [49:0]          prod2;
  logic signed [ScoreBits-1:0] score;
  logic                 out_free;
  logic                 cnt_done;
  step_req_t            req;
  step_rsp_t            rsp;

  assign out_free    = ~out_ch.valid | out_ch.ready;
  assign in_ch.ready = (state == S_IDLE);
  assign mag   = in_ch.child_value_sum[SumBits-1] ? (~in_ch.child_value_sum + 1'b1)
                                                  : in_ch.child_value_sum;
  assign prod2 = prod1 * parent_root;
  assign score = ScoreBits'(q) + ScoreBits'({1'b0, u});

  // Shared unit operands: Q divides by the visit count, U by one more
  assign req.op      = (state == S_SQRT) ? OP_SQRT : OP_DIV;
  assign req.rem     = rem;
  assign req.top     = acc[AccBits-1 -: 2];
  assign req.divisor = (state == S_QDIV) ? {1'b0, visits} : {1'b0, visits} + 1'b1;
  assign req.root    = root;

  pcs_step_unit u_step (
    .req (req),
    .rsp (rsp)
  );

  // Weight register
  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= WgtReset;
    end else if (cfg_we) begin
      weight <= cfg_wdata;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    cnt_done   = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid) begin
          priority if (in_ch.empty_group) state_next = S_FINISH;
          else if (!in_group)             state_next = S_SQRT;
          else if (in_ch.child_visits == '0) state_next = S_MUL1;
          else                            state_next = S_QDIV;
        end
      end
      S_SQRT: begin
        cnt_done = (cnt == CntBits'(SqrtSteps - 1));
        if (cnt_done) state_next = (visits == '0) ? S_MUL1 : S_QDIV;
      end
      S_QDIV: begin
        cnt_done = (cnt == CntBits'(DivSteps - 1));
        if (cnt_done) state_next = S_MUL1;
      end
      S_MUL1: state_next = S_MUL2;
      S_MUL2: state_next = S_UDIV;
      S_UDIV: begin
        cnt_done = (cnt == CntBits'(DivSteps - 1));
        if (cnt_done) state_next = S_CMP;
      end
      S_CMP:    state_next = last ? S_FINISH : S_IDLE;
      S_FINISH: if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Group control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_group    <= 1'b0;
      parent_zero <= 1'b0;
    end else if (state == S_IDLE && in_ch.valid) begin
      if (in_ch.empty_group) begin
        in_group <= 1'b0;
      end else if (!in_group) begin
        in_group    <= 1'b1;
        parent_zero <= (in_ch.parent_visits == '0);
      end
    end else if (state == S_FINISH && out_free) begin
      in_group <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    priority case (state)
      S_IDLE: begin
        cnt    <= '0;
        rem    <= '0;
        root   <= '0;
        q      <= '0;
        id     <= in_ch.child_id;
        visits <= in_ch.child_visits;
        prior  <= in_ch.child_prior;
        neg    <= in_ch.child_value_sum[SumBits-1];
        last   <= in_ch.last_child;
        empty  <= in_ch.empty_group;
        first  <= ~in_group;
        acc    <= in_group ? {mag, 4'b0} : {in_ch.parent_visits, 16'b0};
      end
      S_SQRT: begin
        cnt  <= cnt_done ? '0 : cnt + 1'b1;
        rem  <= cnt_done ? '0 : rsp.rem;
        root <= {root[RootBits-2:0], rsp.qbit};
        acc  <= cnt_done ? {sum_mag, 4'b0} : {acc[AccBits-3:0], 2'b00};
        if (cnt_done) parent_root <= {root[RootBits-2:0], rsp.qbit};
      end
      S_QDIV: begin
        cnt <= cnt_done ? '0 : cnt + 1'b1;
        rem <= rsp.rem;
        acc <= {acc[AccBits-2:0], rsp.qbit};
        if (cnt_done) begin
          q <= neg ? -QBits'({acc[SumBits-2:0], rsp.qbit})
                   : QBits'({acc[SumBits-2:0], rsp.qbit});
        end
      end
      S_MUL1: prod1 <= weight * prior;
      S_MUL2: begin
        rem <= '0;
        cnt <= '0;
        acc <= {2'b00, prod2[49:20], 4'b0};
      end
      S_UDIV: begin
        cnt <= cnt_done ? '0 : cnt + 1'b1;
        rem <= rsp.rem;
        acc <= {acc[AccBits-2:0], rsp.qbit};
        if (cnt_done) u <= {acc[UBits-2:0], rsp.qbit};
      end
      S_CMP: begin
        if (first || score > best_score) begin
          best_score <= score;
          best_id    <= id;
        end
      end
      default: ;
    endcase
  end

  // Keep the first child's value sum magnitude while the root is found
  always_ff @(posedge clk) begin
    if (state == S_IDLE) sum_mag <= mag;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (state == S_FINISH && out_free) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      priority if (empty) begin
        out_ch.best_child <= '0;
        out_ch.status     <= ST_EMPTY;
      end else if (parent_zero) begin
        out_ch.best_child <= '0;
        out_ch.status     <= ST_PARENTZERO;
      end else begin
        out_ch.best_child <= best_id;
        out_ch.status     <= ST_OK;
      end
    end
  end

  // An accepted item keeps the block busy in the next cycle
  assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input taken while busy");

  // An error result never names a child
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.status != ST_OK |-> out_ch.best_child == '0)
    else $error("error result carries a child id");

  // Step counter stays inside the division length
  assert property (@(posedge clk) disable iff (rst)
    cnt < CntBits'(DivSteps) || state == S_IDLE)
    else $error("step counter overrun");

endmodule

### rtl/pcs_step_unit.sv
// Shared compare-subtract unit: one restoring division step or one
// digit-by-digit square root step. Depends on pcs_pkg.
`timescale 1ns / 1ps
module pcs_step_unit
  import pcs_pkg::*;
(
  input  step_req_t req,
  output step_rsp_t rsp
);

  logic [RemBits-1:0] rem_sh;
  logic [RemBits-1:0] trial;
  logic [RemBits:0]   diff;

  // Shift in the next dividend bit or radicand pair and pick the trial value
  always_comb begin
    unique case (req.op)
      OP_DIV: begin
        rem_sh = {req.rem[RemBits-2:0], req.top[1]};
        trial  = RemBits'(req.divisor);
      end
      OP_SQRT: begin
        rem_sh = {req.rem[RemBits-3:0], req.top};
        trial  = RemBits'({req.root, 2'b01});
      end
      default: begin
        rem_sh = '0;
        trial  = '0;
      end
    endcase
    diff     = {1'b0, rem_sh} - {1'b0, trial};
    rsp.qbit = ~diff[RemBits];
    rsp.rem  = rsp.qbit ? diff[RemBits-1:0] : rem_sh;
  end

endmodule
